// ===== hdl/fnc_pkg.sv =====
package fnc_pkg;

    // fixed point
    localparam int unsigned Q24_ONE = 32'd16777216;

    // scale factors, Q0.24
    localparam int SCALE_CONT    = 25166;
    localparam int SCALE_DETAIL  = 167772;
    localparam int SCALE_CLIMATE = 20133;

    // seed offsets
    localparam logic [31:0] SEED_CONT        = 32'd747796405;
    localparam logic [31:0] SEED_CLIMATE     = 32'd2246822519;
    localparam logic [31:0] OCTAVE_SEED_STEP = 32'd101;

    // hash multipliers
    localparam logic [31:0] HASH_MUL_X = 32'h27d4eb2d;
    localparam logic [31:0] HASH_MUL_Z = 32'h165667b1;
    localparam logic [31:0] HASH_MUL_A = 32'h85ebca6b;
    localparam logic [31:0] HASH_MUL_B = 32'hc2b2ae35;

    // climate thresholds
    localparam logic [23:0] SNOWY_LIMIT  = 24'd4194304;
    localparam logic [23:0] DESERT_LIMIT = 24'd12582912;

    // biome codes
    localparam logic [1:0] BIOME_SNOWY  = 2'd0;
    localparam logic [1:0] BIOME_PLAINS = 2'd1;
    localparam logic [1:0] BIOME_DESERT = 2'd2;

    // pipeline depths
    localparam int FIELD_LATENCY = 10;
    localparam int TOTAL_LATENCY = 13;

endpackage

// ===== hdl/fractal_noise_column_generator.sv =====
// Fractal value-noise terrain column generator.
// Input stream s_*: one transaction per column, tdata = {column_z, column_x}.
// Output stream m_*: one transaction per column, tdata carries the surface
// height (7-bit signed) and the biome class (0 snowy, 1 plains, 2 desert).
// cfg_we/cfg_wdata write world_seed; write it only while no column is in flight.
// An input column's result reaches m_* through the pipeline's register stages.
// Throughput is one column per cycle while m_* is not stalled: the three noise
// fields (scale, hash multiplies, smoothstep, blends, octave sum, divide) and
// the height stages are fully pipelined, and a new column enters each cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated, and columns keep entering
// until the last stage is occupied.
// Reset clears world_seed to zero and all valid bits; results in flight
// are dropped.
module fractal_noise_column_generator #(
    parameter int OCTAVE_COUNT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // column_x [31:0], column_z [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // surface_height [6:0], biome_class [8:7]
);

    localparam int LAT = fnc_pkg::TOTAL_LATENCY;

    logic        en;
    logic [31:0] world_seed_reg;
    logic [LAT-1:0] valid_reg;

    assign en       = !valid_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[LAT-1];

    // seed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            world_seed_reg <= '0;
        end else if (cfg_we) begin
            world_seed_reg <= cfg_wdata;
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
        end
    end

    logic signed [31:0] cx, cz;
    assign cx = s_tdata[31:0];
    assign cz = s_tdata[63:32];

    logic [23:0] cont_val, detail_val, clim_val;

    fnc_field #(.OCTAVE_COUNT(OCTAVE_COUNT), .SCALE(fnc_pkg::SCALE_CONT)) u_cont (
        .aclk(aclk), .en(en), .coord_x(cx), .coord_z(cz),
        .seed(world_seed_reg + fnc_pkg::SEED_CONT), .value(cont_val)
    );
    fnc_field #(.OCTAVE_COUNT(OCTAVE_COUNT), .SCALE(fnc_pkg::SCALE_DETAIL)) u_detail (
        .aclk(aclk), .en(en), .coord_x(cx), .coord_z(cz),
        .seed(world_seed_reg), .value(detail_val)
    );
    fnc_field #(.OCTAVE_COUNT(OCTAVE_COUNT), .SCALE(fnc_pkg::SCALE_CLIMATE)) u_clim (
        .aclk(aclk), .en(en), .coord_x(cx), .coord_z(cz),
        .seed(world_seed_reg + fnc_pkg::SEED_CLIMATE), .value(clim_val)
    );

    // stage 11: base, amplitude, centered detail
    logic signed [31:0] base_reg, amp_reg;
    logic signed [25:0] dev_reg;
    logic [23:0] clim11_reg, clim12_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            base_reg   <= -32'sd234881024 + 32'(cont_val) * 32'sd24;
            amp_reg    <= 32'sd67108864 + 32'(cont_val) * 32'sd16;
            dev_reg    <= $signed({1'b0, detail_val, 1'b0}) - 26'sd16777216;
            clim11_reg <= clim_val;
        end
    end

    // stage 12: height in Q.48
    logic signed [55:0] sum_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg    <= ($signed(56'(base_reg)) <<< 24)
                        + $signed(56'(dev_reg)) * $signed(56'(amp_reg));
            clim12_reg <= clim11_reg;
        end
    end

    // stage 13: truncate toward zero, classify climate
    logic [7:0] hi;
    logic [7:0] height;
    logic [1:0] biome;
    assign hi     = sum_reg[55:48];
    assign height = (sum_reg[55] && (sum_reg[47:0] != '0)) ? hi + 8'd1 : hi;
    always_comb begin
        priority if (clim12_reg < fnc_pkg::SNOWY_LIMIT) begin
            biome = fnc_pkg::BIOME_SNOWY;
        end else if (clim12_reg > fnc_pkg::DESERT_LIMIT) begin
            biome = fnc_pkg::BIOME_DESERT;
        end else begin
            biome = fnc_pkg::BIOME_PLAINS;
        end
    end

    logic [6:0] height_reg;
    logic [1:0] biome_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            height_reg <= height[6:0];
            biome_reg  <= biome;
        end
    end

    assign m_tdata = {7'd0, biome_reg, height_reg};

endmodule

// ===== hdl/fnc_field.sv =====
module fnc_field #(
    parameter int OCTAVE_COUNT = 4,
    parameter int SCALE        = 25166
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_z,
    input  logic [31:0]        seed,
    output logic [23:0]        value
);

    localparam int TW = 24 + OCTAVE_COUNT;
    localparam int SH = 24 + 2 * OCTAVE_COUNT;
    localparam int MW = 26 + OCTAVE_COUNT;
    localparam int PW = TW + MW;
    localparam longint unsigned DIV = (64'd1 << OCTAVE_COUNT) - 64'd1;
    localparam longint unsigned RECIP = (64'd1 << SH) / DIV;
    localparam logic signed [18:0] SCALE_S = 19'(SCALE);

    // stage 1: scale the coordinates
    logic signed [50:0] px_reg, pz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= coord_x * SCALE_S;
            pz_reg <= coord_z * SCALE_S;
        end
    end

    logic [63:0] pxe, pze;
    assign pxe = {{13{px_reg[50]}}, px_reg};
    assign pze = {{13{pz_reg[50]}}, pz_reg};

    logic [23:0] oct_val [OCTAVE_COUNT];

    genvar k;
    generate
        for (k = 0; k < OCTAVE_COUNT; k++) begin : g_oct
            logic [63:0] shx, shz;
            logic [31:0] x0, z0;
            logic [31:0] seed_k;
            logic [31:0] hx_reg [2];
            logic [31:0] hz_reg [2];
            logic [23:0] tx_reg, tz_reg;
            logic [47:0] tsqx_reg, tsqz_reg;
            logic [31:0] h3_reg [4];
            logic [31:0] h4_reg [4];
            logic [23:0] v5_reg [4];
            logic [24:0] sx3_reg, sz3_reg, sx4_reg, sz4_reg, sx5_reg, sz5_reg;
            logic [24:0] sz6_reg;
            logic [23:0] r0_reg, r1_reg, val_reg;
            logic [25:0] fx, fz;
            logic [49:0] spx, spz;
            logic [31:0] h3m [4];
            logic [31:0] h4m [4];
            logic [48:0] b0, b1, b2;

            assign shx = pxe << k;
            assign shz = pze << k;
            assign x0 = shx[55:24];
            assign z0 = shz[55:24];
            assign seed_k = seed + 32'(k) * fnc_pkg::OCTAVE_SEED_STEP;

            // stage 2: corner coordinate products, fraction squares
            always_ff @(posedge aclk) begin
                if (en) begin
                    hx_reg[0] <= x0 * fnc_pkg::HASH_MUL_X;
                    hx_reg[1] <= (x0 + 32'd1) * fnc_pkg::HASH_MUL_X;
                    hz_reg[0] <= z0 * fnc_pkg::HASH_MUL_Z;
                    hz_reg[1] <= (z0 + 32'd1) * fnc_pkg::HASH_MUL_Z;
                    tx_reg    <= shx[23:0];
                    tz_reg    <= shz[23:0];
                    tsqx_reg  <= 48'(shx[23:0]) * 48'(shx[23:0]);
                    tsqz_reg  <= 48'(shz[23:0]) * 48'(shz[23:0]);
                end
            end

            // stage 3: seed mix and first hash multiply, smoothstep
            assign fx  = 26'(3 * fnc_pkg::Q24_ONE) - {1'b0, tx_reg, 1'b0};
            assign fz  = 26'(3 * fnc_pkg::Q24_ONE) - {1'b0, tz_reg, 1'b0};
            assign spx = 50'(tsqx_reg[47:24]) * 50'(fx);
            assign spz = 50'(tsqz_reg[47:24]) * 50'(fz);
            always_comb begin
                for (int j = 0; j < 4; j++) begin
                    h3m[j] = seed_k ^ hx_reg[j % 2] ^ hz_reg[j / 2];
                    h3m[j] = h3m[j] ^ (h3m[j] >> 15);
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    for (int j = 0; j < 4; j++) begin
                        h3_reg[j] <= h3m[j] * fnc_pkg::HASH_MUL_A;
                    end
                    sx3_reg <= spx[48:24];
                    sz3_reg <= spz[48:24];
                end
            end

            // stage 4: second hash multiply
            always_comb begin
                for (int j = 0; j < 4; j++) begin
                    h4m[j] = h3_reg[j] ^ (h3_reg[j] >> 13);
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    for (int j = 0; j < 4; j++) begin
                        h4_reg[j] <= h4m[j] * fnc_pkg::HASH_MUL_B;
                    end
                    sx4_reg <= sx3_reg;
                    sz4_reg <= sz3_reg;
                end
            end

            // stage 5: final avalanche, lattice values
            always_ff @(posedge aclk) begin
                if (en) begin
                    for (int j = 0; j < 4; j++) begin
                        v5_reg[j] <= h4_reg[j][23:0] ^ {8'd0, h4_reg[j][31:16]};
                    end
                    sx5_reg <= sx4_reg;
                    sz5_reg <= sz4_reg;
                end
            end

            // stage 6: blend along x
            assign b0 = 49'(v5_reg[0]) * 49'(25'(fnc_pkg::Q24_ONE) - sx5_reg)
                      + 49'(v5_reg[1]) * 49'(sx5_reg);
            assign b1 = 49'(v5_reg[2]) * 49'(25'(fnc_pkg::Q24_ONE) - sx5_reg)
                      + 49'(v5_reg[3]) * 49'(sx5_reg);
            always_ff @(posedge aclk) begin
                if (en) begin
                    r0_reg  <= b0[47:24];
                    r1_reg  <= b1[47:24];
                    sz6_reg <= sz5_reg;
                end
            end

            // stage 7: blend along z
            assign b2 = 49'(r0_reg) * 49'(25'(fnc_pkg::Q24_ONE) - sz6_reg)
                      + 49'(r1_reg) * 49'(sz6_reg);
            always_ff @(posedge aclk) begin
                if (en) begin
                    val_reg <= b2[47:24];
                end
            end
            assign oct_val[k] = val_reg;
        end
    endgenerate

    // stage 8: octave weighted sum
    logic [TW-1:0] total_next, total_reg;
    always_comb begin
        total_next = '0;
        for (int i = 0; i < OCTAVE_COUNT; i++) begin
            total_next = total_next + (TW'(oct_val[i]) << (OCTAVE_COUNT - 1 - i));
        end
    end

    // stage 9: reciprocal multiply
    logic [TW-1:0] total9_reg;
    logic [PW-1:0] prod_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            total_reg  <= total_next;
            total9_reg <= total_reg;
            prod_reg   <= PW'(total_reg) * PW'(MW'(RECIP));
        end
    end

    // stage 10: quotient correction
    logic [23:0] q_est;
    logic [TW-1:0] rem;
    logic [23:0] value_reg;
    assign q_est = prod_reg[SH +: 24];
    assign rem   = total9_reg - TW'(q_est) * TW'(DIV);
    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= (rem >= TW'(DIV)) ? q_est + 24'd1 : q_est;
        end
    end
    assign value = value_reg;

endmodule

// ===== hdl/fnc_checker.sv =====
module fnc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // biome code is never the unused one
    a_biome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8:7] != 2'd3)
        else $error("bad biome class");

    // height stays within its range
    a_height: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[6:0]) >= -7'sd34) && ($signed(m_tdata[6:0]) <= 7'sd30))
        else $error("height out of range");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");

    // an empty output stage never blocks input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output empty");

endmodule

bind fractal_noise_column_generator fnc_checker u_fnc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== test/fractal_noise_column_generator_tb.sv =====
module fractal_noise_column_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // expected terrain of one column transaction
    typedef struct packed {
        logic [6:0] height;
        logic [1:0] biome;
    } terrain_t;

    // terrain prediction and the queue of expected columns
    class terrain_scoreboard;
        logic [31:0] seed;
        terrain_t pending[$];
        int errors;

        function new();
            seed = 32'd0;
            errors = 0;
        endfunction

        function logic [31:0] corner_hash(logic [31:0] s, logic [31:0] cx, logic [31:0] cz);
            logic [31:0] h;
            h = s;
            h ^= cx * fnc_pkg::HASH_MUL_X;
            h ^= cz * fnc_pkg::HASH_MUL_Z;
            h ^= h >> 15;
            h = h * fnc_pkg::HASH_MUL_A;
            h ^= h >> 13;
            h = h * fnc_pkg::HASH_MUL_B;
            h ^= h >> 16;
            return h;
        endfunction

        function longint unsigned smooth(longint unsigned t);
            longint unsigned t2;
            t2 = (t * t) >> 24;
            return (t2 * (3 * 64'd16777216 - 2 * t)) >> 24;
        endfunction

        function longint unsigned mix(longint unsigned a, longint unsigned b,
                                      longint unsigned w);
            return (a * (64'd16777216 - w) + b * w) >> 24;
        endfunction

        function longint unsigned noise_field(logic [31:0] s, longint cx, longint cz,
                                              longint scale);
            longint unsigned total, sx, sz, v00, v10, v01, v11;
            logic [63:0] px, pz;
            logic [31:0] x0, z0, os;
            total = 0;
            for (int k = 0; k < 4; k++) begin
                px = cx * scale * (64'sd1 <<< k);
                pz = cz * scale * (64'sd1 <<< k);
                x0 = px[55:24];
                z0 = pz[55:24];
                sx = smooth(64'(px[23:0]));
                sz = smooth(64'(pz[23:0]));
                os = s + 32'(k) * fnc_pkg::OCTAVE_SEED_STEP;
                v00 = 64'(corner_hash(os, x0, z0) & 32'hFFFFFF);
                v10 = 64'(corner_hash(os, x0 + 32'd1, z0) & 32'hFFFFFF);
                v01 = 64'(corner_hash(os, x0, z0 + 32'd1) & 32'hFFFFFF);
                v11 = 64'(corner_hash(os, x0 + 32'd1, z0 + 32'd1) & 32'hFFFFFF);
                total += mix(mix(v00, v10, sx), mix(v01, v11, sx), sz) << (3 - k);
            end
            return total / 15;
        endfunction

        // note an accepted column
        function void note_column(logic [63:0] data);
            longint cx, cz, c, d, one, sum, hgt;
            longint unsigned clim;
            terrain_t t;
            cx = longint'($signed(data[31:0]));
            cz = longint'($signed(data[63:32]));
            c = noise_field(seed + fnc_pkg::SEED_CONT, cx, cz, fnc_pkg::SCALE_CONT);
            d = noise_field(seed, cx, cz, fnc_pkg::SCALE_DETAIL);
            clim = noise_field(seed + fnc_pkg::SEED_CLIMATE, cx, cz, fnc_pkg::SCALE_CLIMATE);
            one = 64'sd16777216;
            sum = (-14 * one + 24 * c) * one + (2 * d - one) * (4 * one + 16 * c);
            hgt = sum / (64'sd1 <<< 48);
            t.height = hgt[6:0];
            if (clim < 64'(fnc_pkg::SNOWY_LIMIT)) t.biome = fnc_pkg::BIOME_SNOWY;
            else if (clim > 64'(fnc_pkg::DESERT_LIMIT)) t.biome = fnc_pkg::BIOME_DESERT;
            else t.biome = fnc_pkg::BIOME_PLAINS;
            pending.push_back(t);
        endfunction

        // check one result transaction
        function void check_terrain(logic [15:0] data);
            terrain_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", data);
                return;
            end
            e = pending.pop_front();
            if (data[6:0] !== e.height || data[8:7] !== e.biome) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: height exp %0d got %0d, biome exp %0d got %0d",
                             $signed(e.height), $signed(data[6:0]), e.biome, data[8:7]);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    terrain_scoreboard sb = new();
    int rx_wait = 0;

    fractal_noise_column_generator dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    // result side: random ready delay per transaction, then checking
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = $urandom_range(0, 7);
        end else if (m_tvalid && m_tready) begin
            sb.check_terrain(m_tdata);
            rx_wait = $urandom_range(0, 7);
            m_tready <= (rx_wait == 0);
        end else if (!m_tready) begin
            if (rx_wait > 1) rx_wait = rx_wait - 1;
            else m_tready <= 1'b1;
        end
    end

    task automatic send_column(logic [31:0] x, logic [31:0] z, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, x};
        do @(posedge aclk); while (!s_tready);
        sb.note_column({z, x});
    endtask

    task automatic drain_columns();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (fnc_pkg::TOTAL_LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_seed(logic [31:0] v);
        drain_columns();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.seed = v;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 4000) - 2000;
            2: return 32'h8000_0000 + $urandom_range(0, 8);
            3: return 32'h7FFF_FFFF - $urandom_range(0, 8);
            default: return $urandom_range(0, 200000) - 100000;
        endcase
    endfunction

    initial begin
        logic [31:0] edge_vals[6] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000,
                                     32'h7FFF_FFFF, 32'd1, 32'hAAAA_5555};
        logic [31:0] seeds[4] = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h0};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed extremes under the reset seed
        foreach (edge_vals[i]) begin
            send_column(edge_vals[i], edge_vals[(i + 2) % 6], 0);
            send_column(edge_vals[(i + 3) % 6], edge_vals[i], $urandom_range(0, 2));
        end
        drain_columns();

        // random phases, one per seed
        for (int p = 0; p < 5; p++) begin
            write_seed(p < 4 ? seeds[p] : $urandom());
            for (int n = 0; n < 380; n++) begin
                send_column(pick_coord(), pick_coord(),
                            ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 0);
                if (n == 200) drain_columns();
            end
        end
        drain_columns();
        if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end
endmodule
